// ----- design/pfa_pkg.sv -----
// shared types and constants of the pareto front archive
package pfa_pkg;

  localparam int FRONT_DEPTH  = 64;
  localparam int FITNESS_BITS = 32;
  localparam int SIZE_BITS    = 16;
  localparam int TREES_BITS   = 8;
  localparam int IDENT_BITS   = 64;
  localparam int IDX_W        = $clog2(FRONT_DEPTH);
  localparam int CNT_W        = 7;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [FITNESS_BITS-1:0] fitness;
    logic [SIZE_BITS-1:0]    tree_size;
    logic [TREES_BITS-1:0]   tree_count;
    logic [IDENT_BITS-1:0]   rep_id;
    logic [IDX_W-1:0]        read_index;
  } req_t;

  typedef struct packed {
    logic                    accepted;
    logic [CNT_W-1:0]        evicted_count;
    logic [CNT_W-1:0]        front_count;
    logic                    full_reject;
    logic                    rd_valid;
    logic [FITNESS_BITS-1:0] rd_fitness;
    logic [SIZE_BITS-1:0]    rd_tree_size;
    logic [TREES_BITS-1:0]   rd_tree_count;
    logic [IDENT_BITS-1:0]   rd_rep_id;
  } res_t;

  typedef struct packed {
    logic [FITNESS_BITS-1:0] fitness;
    logic [SIZE_BITS-1:0]    tree_size;
    logic [TREES_BITS-1:0]   tree_count;
    logic [IDENT_BITS-1:0]   rep_id;
  } entry_t;

endpackage

// ----- design/pfa_ram.sv -----
// generic single write port, single read port ram with registered read
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pareto_front_archive_top.sv -----
// top level of the two-objective pareto front archive
//
// A request is taken when start is high and busy is low. It either inserts
// a candidate (fitness, size, tree count, identity) or reads one archive slot.
// Exactly one result follows each request: done_o is high for one cycle and
// res_o holds the result during that cycle. The receiver cannot stall, so the
// result is lost if not taken in that cycle.
// A read passes through the registered read of the entry ram and then the
// registered result.
// An insert walks every held entry once through the single read port of the
// entry ram and writes the survivors back compacted through its write port,
// one entry per cycle; the result is registered in a final state that
// appends the candidate when it is accepted.
// busy stays high from acceptance until the result cycle.
// Reset empties the archive at once (the entry count goes to zero); the ram
// contents are never read before they are written, so no clearing pass runs.
module pareto_front_archive_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pfa_pkg::req_t req_i,
  output logic          done_o,
  output pfa_pkg::res_t res_o
);

  import pfa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e           state_q;
  req_t             req_q;
  res_t             res_q;
  res_t             res_d;
  logic             done_q;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] total_d;
  logic [CNT_W-1:0] r_q;
  logic [CNT_W-1:0] w_q;
  logic [CNT_W-1:0] evict_q;
  logic             pend_q;
  logic             evany_q;
  logic             worse_q;
  logic             same_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic is_same;
  logic is_dom;
  logic is_worse;
  logic keep;
  logic app_cond;
  logic app_ok;
  logic rd_ok;

  pfa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(FRONT_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    is_same  = (req_q.fitness == ram_rdata.fitness) &&
               (req_q.tree_size == ram_rdata.tree_size) &&
               (req_q.rep_id == ram_rdata.rep_id);
    is_dom   = ((req_q.fitness < ram_rdata.fitness) &&
                (req_q.tree_size <= ram_rdata.tree_size)) ||
               ((req_q.fitness <= ram_rdata.fitness) &&
                (req_q.tree_size < ram_rdata.tree_size)) ||
               (req_q.rep_id == ram_rdata.rep_id);
    is_worse = (req_q.fitness >= ram_rdata.fitness) &&
               (req_q.tree_size >= ram_rdata.tree_size) &&
               !((req_q.fitness == ram_rdata.fitness) &&
                 (req_q.tree_size == ram_rdata.tree_size));
    keep     = is_same || !is_dom;
    app_cond = (evany_q || !worse_q) && !same_q;
    app_ok   = app_cond && (w_q < CNT_W'(FRONT_DEPTH));
    rd_ok    = {1'b0, req_q.read_index} < total_q;
    total_d  = app_ok ? w_q + 1'b1 : w_q;
    res_d    = '0;
    if (state_q == ST_READ) begin
      res_d.front_count = total_q;
      res_d.rd_valid    = rd_ok;
      if (rd_ok) begin
        res_d.rd_fitness    = ram_rdata.fitness;
        res_d.rd_tree_size  = ram_rdata.tree_size;
        res_d.rd_tree_count = ram_rdata.tree_count;
        res_d.rd_rep_id     = ram_rdata.rep_id;
      end
    end else begin
      res_d.accepted      = app_ok;
      res_d.full_reject   = app_cond && !app_ok;
      res_d.evicted_count = evict_q;
      res_d.front_count   = total_d;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = r_q[IDX_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = req_i.read_index;
      end
      ST_SCAN: begin
        ram_we = pend_q && keep;
      end
      ST_FIN: begin
        ram_we    = app_ok;
        ram_wdata = '{fitness:    req_q.fitness,
                      tree_size:  req_q.tree_size,
                      tree_count: req_q.tree_count,
                      rep_id:     req_q.rep_id};
      end
      ST_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      total_q <= '0;
      r_q     <= '0;
      w_q     <= '0;
      evict_q <= '0;
      pend_q  <= 1'b0;
      evany_q <= 1'b0;
      worse_q <= 1'b0;
      same_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            req_q   <= req_i;
            r_q     <= '0;
            w_q     <= '0;
            evict_q <= '0;
            pend_q  <= 1'b0;
            evany_q <= 1'b0;
            worse_q <= 1'b0;
            same_q  <= 1'b0;
            state_q <= (req_i.req_type == REQ_READ) ? ST_READ : ST_SCAN;
          end
        end
        ST_READ: begin
          res_q   <= res_d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_SCAN: begin
          done_q <= 1'b0;
          // process entry r_q-1 while entry r_q is being read
          if (pend_q) begin
            if (is_same) begin
              same_q <= 1'b1;
            end else if (is_dom) begin
              evany_q <= 1'b1;
              evict_q <= evict_q + 1'b1;
            end else if (is_worse) begin
              worse_q <= 1'b1;
            end
            if (keep) begin
              w_q <= w_q + 1'b1;
            end
          end
          if (r_q < total_q) begin
            r_q    <= r_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q  <= 1'b0;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_q   <= res_d;
          total_q <= total_d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- tb/pfa_checker.sv -----
// checker that predicts and compares every result of the pareto front archive
module pfa_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  pfa_pkg::req_t req_i,
  input  logic          done_i,
  input  pfa_pkg::res_t res_i,
  output int unsigned   fail_cnt_o,
  output int unsigned   pending_o
);

  import pfa_pkg::*;

  entry_t      front_mem [FRONT_DEPTH];
  int unsigned front_len;
  res_t        due_results [$];
  int unsigned mism;

  function automatic res_t archive_update(input req_t rq);
    res_t        res;
    entry_t      cur;
    int unsigned kept;
    int unsigned dropped;
    logic        any_drop;
    logic        any_worse;
    logic        twin;
    logic        keep;
    res       = '0;
    kept      = 0;
    dropped   = 0;
    any_drop  = 1'b0;
    any_worse = 1'b0;
    twin      = 1'b0;
    if (rq.req_type == REQ_READ) begin
      res.front_count = CNT_W'(front_len);
      if (rq.read_index < front_len) begin
        res.rd_valid      = 1'b1;
        res.rd_fitness    = front_mem[rq.read_index].fitness;
        res.rd_tree_size  = front_mem[rq.read_index].tree_size;
        res.rd_tree_count = front_mem[rq.read_index].tree_count;
        res.rd_rep_id     = front_mem[rq.read_index].rep_id;
      end
      return res;
    end
    for (int r = 0; r < front_len; r++) begin
      cur  = front_mem[r];
      keep = 1'b1;
      if (rq.fitness == cur.fitness && rq.tree_size == cur.tree_size &&
          rq.rep_id == cur.rep_id) begin
        twin = 1'b1;
      end else if ((rq.fitness < cur.fitness && rq.tree_size <= cur.tree_size) ||
                   (rq.fitness <= cur.fitness && rq.tree_size < cur.tree_size) ||
                   rq.rep_id == cur.rep_id) begin
        any_drop = 1'b1;
        dropped++;
        keep = 1'b0;
      end else if (rq.fitness >= cur.fitness && rq.tree_size >= cur.tree_size &&
                   !(rq.fitness == cur.fitness && rq.tree_size == cur.tree_size)) begin
        any_worse = 1'b1;
      end
      if (keep) begin
        front_mem[kept] = cur;
        kept++;
      end
    end
    if ((any_drop || !any_worse) && !twin) begin
      if (kept < FRONT_DEPTH) begin
        front_mem[kept].fitness    = rq.fitness;
        front_mem[kept].tree_size  = rq.tree_size;
        front_mem[kept].tree_count = rq.tree_count;
        front_mem[kept].rep_id     = rq.rep_id;
        kept++;
        res.accepted = 1'b1;
      end else begin
        res.full_reject = 1'b1;
      end
    end
    front_len         = kept;
    res.evicted_count = CNT_W'(dropped);
    res.front_count   = CNT_W'(kept);
    return res;
  endfunction

  task automatic show(input string tag, input res_t r);
    $display("  %s: acc=%0d evict=%0d count=%0d full=%0d rd_valid=%0d",
             tag, r.accepted, r.evicted_count, r.front_count, r.full_reject, r.rd_valid);
    $display("  %s: fit=%h size=%h trees=%h id=%h",
             tag, r.rd_fitness, r.rd_tree_size, r.rd_tree_count, r.rd_rep_id);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : mon
    res_t want;
    if (!rst_ni) begin
      front_len = 0;
      mism      = 0;
      due_results.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (done_i) begin
        if (due_results.size() == 0) begin
          if (mism < 10) begin
            $display("result at %0t with no transaction outstanding", $time);
            show("got", res_i);
          end
          mism++;
        end else begin
          want = due_results.pop_front();
          if (res_i.accepted !== want.accepted ||
              res_i.evicted_count !== want.evicted_count ||
              res_i.front_count !== want.front_count ||
              res_i.full_reject !== want.full_reject ||
              res_i.rd_valid !== want.rd_valid ||
              res_i.rd_fitness !== want.rd_fitness ||
              res_i.rd_tree_size !== want.rd_tree_size ||
              res_i.rd_tree_count !== want.rd_tree_count ||
              res_i.rd_rep_id !== want.rd_rep_id) begin
            if (mism < 10) begin
              $display("result mismatch at %0t", $time);
              show("exp", want);
              show("got", res_i);
            end
            mism++;
          end
        end
      end
      if (start_i && !busy_i) begin
        due_results.insert(due_results.size(), archive_update(req_i));
      end
      fail_cnt_o <= mism;
      pending_o  <= due_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// testbench top: stimulus, watchdog and verdict for the pareto front archive
module tb;
  import pfa_pkg::*;

  localparam int ITEMS       = 800;
  localparam int CYCLE_LIMIT = 500000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  req_t        req_i  = '0;
  logic        busy;
  logic        done_o;
  res_t        res_o;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned sent   = 0;
  int unsigned cycles = 0;
  logic        idle_on = 1'b0;

  pareto_front_archive_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  pfa_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req_i),
    .done_i     (done_o),
    .res_i      (res_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[pareto_front_archive_top] ERROR");
      $finish;
    end
  end

  function automatic req_t make_insert(input logic [FITNESS_BITS-1:0] fit,
                                       input logic [SIZE_BITS-1:0] sz,
                                       input logic [TREES_BITS-1:0] tc,
                                       input logic [IDENT_BITS-1:0] id);
    req_t rq;
    rq.req_type   = REQ_INSERT;
    rq.fitness    = fit;
    rq.tree_size  = sz;
    rq.tree_count = tc;
    rq.rep_id     = id;
    rq.read_index = IDX_W'($urandom_range(0, FRONT_DEPTH - 1));
    return rq;
  endfunction

  function automatic req_t make_read(input int unsigned idx);
    req_t rq;
    rq.req_type   = REQ_READ;
    rq.fitness    = $urandom;
    rq.tree_size  = SIZE_BITS'($urandom);
    rq.tree_count = TREES_BITS'($urandom_range(1, 255));
    rq.rep_id     = {$urandom, $urandom};
    rq.read_index = IDX_W'(idx);
    return rq;
  endfunction

  function automatic logic [TREES_BITS-1:0] rand_trees();
    return TREES_BITS'($urandom_range(1, 255));
  endfunction

  // start stays high across back-to-back transactions
  task automatic issue(input req_t rq);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // the all-zero candidate clears the archive, the worst one with the same id replaces it
  task automatic wipe(input logic [IDENT_BITS-1:0] id);
    issue(make_insert('0, '0, rand_trees(), id));
    issue(make_insert('1, '1, rand_trees(), id));
  endtask

  initial begin : stim
    logic [FITNESS_BITS-1:0] f0;
    logic [FITNESS_BITS-1:0] df;
    logic [FITNESS_BITS-1:0] fb;
    logic [SIZE_BITS-1:0]    s0;
    logic [SIZE_BITS-1:0]    ds;
    logic [SIZE_BITS-1:0]    sb;
    logic [IDENT_BITS-1:0]   pool [8];
    logic [IDENT_BITS-1:0]   stair_id [68];
    req_t                    last_ins;
    int                      j;
    int                      kind;
    int                      n;
    logic                    first;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_on = 1'b1;
    issue(make_read(0));
    issue(make_read(FRONT_DEPTH - 1));
    issue(make_insert('1, '1, 8'd1, '0));
    issue(make_insert('1, '1, 8'd7, '0));
    issue(make_insert('1, '1, 8'd1, 64'd1));
    issue(make_insert('0, '1, 8'd255, '1));
    issue(make_insert(32'd100, '0, 8'h5a, 64'd2));
    issue(make_insert(32'd200, 16'd10, 8'h3c, 64'd3));
    issue(make_insert(32'd50, 16'd5, 8'hc3, 64'd2));
    issue(make_read(0));
    issue(make_read(1));
    issue(make_read(2));
    issue(make_read(FRONT_DEPTH - 1));
    last_ins = make_insert('0, '0, 8'ha5, {$urandom, $urandom});
    issue(last_ins);
    issue(make_read(0));
    issue(make_insert('1, '1, 8'h81, last_ins.rep_id));

    first = 1'b1;
    while (sent < ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = first ? 0 : $urandom_range(0, 9);
      first   = 1'b0;
      if (kind == 0) begin
        // staircase of mutually non-dominated candidates fills the archive
        stair_id[0] = {$urandom, $urandom};
        issue(make_insert('0, '0, rand_trees(), stair_id[0]));
        f0 = $urandom_range(0, 32'h7fff_ffff);
        df = $urandom_range(1, 1000);
        s0 = SIZE_BITS'($urandom_range(50000, 65535));
        ds = SIZE_BITS'($urandom_range(1, 600));
        for (j = 1; j < 68; j++) stair_id[j] = {$urandom, $urandom};
        for (j = 0; j < 68; j++) begin
          issue(make_insert(f0 + j * df, SIZE_BITS'(s0 - j * ds), rand_trees(),
                            stair_id[j]));
        end
        repeat (6) issue(make_read($urandom_range(0, FRONT_DEPTH - 1)));
        j = $urandom_range(1, 63);
        issue(make_insert(f0 + j * df, SIZE_BITS'(s0 - j * ds), rand_trees(), stair_id[j]));
        issue(make_insert(f0 + j * df, SIZE_BITS'(s0 - j * ds + 1), rand_trees(),
                          stair_id[j]));
        settle();
        repeat (4) issue(make_read($urandom_range(0, FRONT_DEPTH - 1)));
        wipe({$urandom, $urandom});
      end else if (kind < 9) begin
        // clustered objectives and a small id pool give frequent dominance and id clashes
        if ($urandom_range(0, 1) == 1) wipe({$urandom, $urandom});
        for (j = 0; j < 8; j++) pool[j] = {$urandom, $urandom};
        fb = $urandom_range(0, 32'hffff_fff0);
        sb = SIZE_BITS'($urandom_range(0, 16'hfff0));
        repeat (20) begin
          n = $urandom_range(0, 19);
          if (n < 5) begin
            issue(make_read(n < 4 ? $urandom_range(0, 7)
                                  : $urandom_range(0, FRONT_DEPTH - 1)));
          end else if (n < 7) begin
            issue(last_ins);
          end else begin
            last_ins = make_insert(fb + $urandom_range(0, 15),
                                   SIZE_BITS'(sb + $urandom_range(0, 15)),
                                   rand_trees(),
                                   n < 14 ? pool[$urandom_range(0, 7)] : {$urandom, $urandom});
            issue(last_ins);
          end
        end
      end else begin
        repeat (10) begin
          if ($urandom_range(0, 1) == 1) begin
            issue(make_read($urandom_range(0, FRONT_DEPTH - 1)));
          end else begin
            issue(make_insert($urandom, SIZE_BITS'($urandom), rand_trees(),
                              {$urandom, $urandom}));
          end
        end
      end
    end

    settle();
    repeat (70) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[pareto_front_archive_top] OK");
    end else begin
      $display("[pareto_front_archive_top] ERROR");
    end
    $finish;
  end

endmodule
